@@ sv/vrp_pkg.sv @@
// Shared widths, register indexes and sine table generator for the vertex transform.
package vrp_pkg;

    localparam int SINE_TABLE_DEPTH_DEF = 1024;
    localparam int COORD_WIDTH_DEF      = 16;

    localparam int VW    = 16;
    localparam int R1W   = 18;
    localparam int R2W   = 20;
    localparam int R3W   = 22;
    localparam int DPW   = 23;
    localparam int DENW  = 23;
    localparam int NW    = 42;
    localparam int TRW   = 14;
    localparam int ROMW  = 13;
    localparam int ANGW  = 12;
    localparam int FRAC  = 12;
    localparam int SCW   = 14;
    localparam int FW    = 16;

    localparam int CFG_IW = 3;
    localparam int CFG_DW = 16;

    localparam logic [CFG_IW-1:0] REG_ANGLE_X       = 3'd0;
    localparam logic [CFG_IW-1:0] REG_ANGLE_Y       = 3'd1;
    localparam logic [CFG_IW-1:0] REG_ANGLE_Z       = 3'd2;
    localparam logic [CFG_IW-1:0] REG_FOCAL_SCALE   = 3'd3;
    localparam logic [CFG_IW-1:0] REG_CAMERA_DIST   = 3'd4;
    localparam logic [CFG_IW-1:0] REG_SCREEN_WIDTH  = 3'd5;
    localparam logic [CFG_IW-1:0] REG_SCREEN_HEIGHT = 3'd6;

    localparam logic [FW-1:0]  FOCAL_RESET  = 16'd200;
    localparam logic [FW-1:0]  CAMERA_RESET = 16'd16384;
    localparam logic [SCW-1:0] WIDTH_RESET  = 14'd1920;
    localparam logic [SCW-1:0] HEIGHT_RESET = 14'd1080;

    localparam longint unsigned PIHALF_Q30 = 64'd1686629713;
    localparam longint unsigned TAYLOR_DIV [8] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

    function automatic logic [ROMW-1:0] taylor_q12(input longint unsigned theta);
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        x2   = (theta * theta) >> 30;
        term = theta;
        sum  = theta;
        for (int n = 0; n < 8; n++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n];
            if (n[0] == 1'b0) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return ROMW'((sum + (64'd1 << 17)) >> 18);
    endfunction

endpackage

@@ sv/vrp_coef.sv @@
// Sine ROM and sequencer that turns the three angles into sine and cosine registers.
module vrp_coef import vrp_pkg::*; #(
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [2:0][ANGW-1:0]          angle,
    output logic                          busy,
    output logic signed [2:0][TRW-1:0]    sin_val,
    output logic signed [2:0][TRW-1:0]    cos_val
);

    localparam int D  = SINE_TABLE_DEPTH;
    localparam int AW = $clog2(D + 1);
    localparam int PW = ANGW + AW;

    logic [ROMW-1:0] rom [0:D];

    for (genvar r = 0; r <= D; r++) begin : g_rom
        localparam longint unsigned Theta =
            (longint'(r) * PIHALF_Q30) / SINE_TABLE_DEPTH;
        assign rom[r] = taylor_q12(Theta);
    end

    logic [2:0][1:0]    k;
    logic [2:0][AW-1:0] r_lo;
    logic [2:0][AW-1:0] r_hi;

    always_comb begin
        logic [PW-1:0]   prod;
        logic [AW+1:0]   q4;
        logic [AW+1:0]   rf;
        for (int i = 0; i < 3; i++) begin
            prod = PW'(angle[i]) * PW'(D);
            q4   = {prod[PW-1:ANGW], 2'b00};
            if (q4 >= (AW+2)'(3 * D)) begin
                k[i] = 2'd3;
                rf   = q4 - (AW+2)'(3 * D);
            end else if (q4 >= (AW+2)'(2 * D)) begin
                k[i] = 2'd2;
                rf   = q4 - (AW+2)'(2 * D);
            end else if (q4 >= (AW+2)'(D)) begin
                k[i] = 2'd1;
                rf   = q4 - (AW+2)'(D);
            end else begin
                k[i] = 2'd0;
                rf   = q4;
            end
            r_lo[i] = AW'(rf);
            r_hi[i] = AW'(D) - AW'(rf);
        end
    end

    logic [2:0]      cnt_reg;
    logic            busy_reg;
    logic [ROMW-1:0] rd_reg;
    logic [ROMW-1:0] q_reg [0:5];
    logic [AW-1:0]   addr;
    logic [1:0]      sel;

    assign sel = cnt_reg[2:1];

    always_comb begin
        unique case (sel)
            2'd0:    addr = cnt_reg[0] ? r_hi[0] : r_lo[0];
            2'd1:    addr = cnt_reg[0] ? r_hi[1] : r_lo[1];
            2'd2:    addr = cnt_reg[0] ? r_hi[2] : r_lo[2];
            default: addr = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 3'd1;
            if (cnt_reg == 3'd7) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        logic signed [TRW-1:0] lo;
        logic signed [TRW-1:0] hi;
        rd_reg <= rom[addr];
        if (busy_reg && cnt_reg != 3'd0 && cnt_reg != 3'd7) begin
            q_reg[cnt_reg - 3'd1] <= rd_reg;
        end
        if (busy_reg && cnt_reg == 3'd7) begin
            for (int i = 0; i < 3; i++) begin
                lo = $signed({1'b0, q_reg[2*i]});
                hi = $signed({1'b0, q_reg[2*i+1]});
                unique case (k[i])
                    2'd0: begin sin_val[i] <= lo;  cos_val[i] <= hi;  end
                    2'd1: begin sin_val[i] <= hi;  cos_val[i] <= -lo; end
                    2'd2: begin sin_val[i] <= -lo; cos_val[i] <= -hi; end
                    default: begin sin_val[i] <= -hi; cos_val[i] <= lo; end
                endcase
            end
        end
    end

    assign busy = busy_reg;

endmodule

@@ sv/vrp_rot.sv @@
// Two-stage plane rotation: registered products, then rounded sum and difference.
module vrp_rot import vrp_pkg::*; #(
    parameter int AW = 16,
    parameter int PW = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [AW-1:0]  a_in,
    input  logic signed [AW-1:0]  b_in,
    input  logic signed [PW-1:0]  p_in,
    input  logic signed [TRW-1:0] sin_val,
    input  logic signed [TRW-1:0] cos_val,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [AW+1:0]  u_out,
    output logic signed [AW+1:0]  v_out,
    output logic signed [PW-1:0]  p_out
);

    localparam int MW = AW + TRW;
    localparam int SW = MW + 1;

    logic v0_reg, v1_reg, ld0, ld1;
    logic signed [MW-1:0] ac_reg, bs_reg, as_reg, bc_reg;
    logic signed [PW-1:0] p0_reg, p1_reg;
    logic signed [AW+1:0] u_reg, v_reg;
    logic signed [SW-1:0] su, sv;

    assign ld1      = !v1_reg || out_ready;
    assign ld0      = !v0_reg || ld1;
    assign in_ready = ld0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else begin
            if (ld0) v0_reg <= in_valid;
            if (ld1) v1_reg <= v0_reg;
        end
    end

    assign su = SW'(ac_reg) - SW'(bs_reg) + SW'(1 << (FRAC - 1));
    assign sv = SW'(as_reg) + SW'(bc_reg) + SW'(1 << (FRAC - 1));

    always_ff @(posedge aclk) begin
        if (ld0) begin
            ac_reg <= MW'(a_in) * MW'(cos_val);
            bs_reg <= MW'(b_in) * MW'(sin_val);
            as_reg <= MW'(a_in) * MW'(sin_val);
            bc_reg <= MW'(b_in) * MW'(cos_val);
            p0_reg <= p_in;
        end
        if (ld1) begin
            u_reg  <= (AW+2)'(su >>> FRAC);
            v_reg  <= (AW+2)'(sv >>> FRAC);
            p1_reg <= p0_reg;
        end
    end

    assign out_valid = v1_reg;
    assign u_out     = u_reg;
    assign v_out     = v_reg;
    assign p_out     = p1_reg;

endmodule

@@ sv/vrp_proj.sv @@
// Depth, focal and screen products and the signed numerators for the perspective divide.
module vrp_proj import vrp_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic signed [R2W-1:0]  x_in,
    input  logic signed [R3W-1:0]  y_in,
    input  logic signed [R3W-1:0]  z_in,
    input  logic [FW-1:0]          cam_dist,
    input  logic [FW-1:0]          focal,
    input  logic [SCW-1:0]         scr_w,
    input  logic [SCW-1:0]         scr_h,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0][NW-1:0]     mag_out,
    output logic [1:0]             neg_out,
    output logic [DENW-1:0]        den_out,
    output logic                   behind_out
);

    localparam int WDW = DPW + SCW + 1;
    localparam int XFW = R2W + FW + 1;
    localparam int YFW = R3W + FW + 1;

    logic [3:0] v_reg, ld;

    assign ld[3] = !v_reg[3] || out_ready;
    assign ld[2] = !v_reg[2] || ld[3];
    assign ld[1] = !v_reg[1] || ld[2];
    assign ld[0] = !v_reg[0] || ld[1];
    assign in_ready = ld[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (ld[0]) v_reg[0] <= in_valid;
            if (ld[1]) v_reg[1] <= v_reg[0];
            if (ld[2]) v_reg[2] <= v_reg[1];
            if (ld[3]) v_reg[3] <= v_reg[2];
        end
    end

    logic signed [DPW-1:0] depth0_reg, depth1_reg;
    logic signed [R2W-1:0] x0_reg;
    logic signed [R3W-1:0] y0_reg;
    logic signed [WDW-1:0] wd_reg, hd_reg;
    logic signed [XFW-1:0] xf_reg;
    logic signed [YFW-1:0] yf_reg;
    logic                  beh1_reg, beh2_reg, beh3_reg;
    logic signed [NW-1:0]  nx_reg, ny_reg;
    logic [DENW-1:0]       den2_reg, den3_reg;
    logic [1:0][NW-1:0]    mag_reg;
    logic [1:0]            neg_reg;

    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            depth0_reg <= DPW'(z_in) + DPW'($signed({1'b0, cam_dist}));
            x0_reg     <= x_in;
            y0_reg     <= y_in;
        end
        if (ld[1]) begin
            wd_reg     <= $signed({1'b0, scr_w}) * depth0_reg;
            hd_reg     <= $signed({1'b0, scr_h}) * depth0_reg;
            xf_reg     <= x0_reg * $signed({1'b0, focal});
            yf_reg     <= y0_reg * $signed({1'b0, focal});
            depth1_reg <= depth0_reg;
            beh1_reg   <= depth0_reg[DPW-1] || (depth0_reg == '0);
        end
        if (ld[2]) begin
            nx_reg   <= NW'(wd_reg) + (NW'(xf_reg) <<< 1) + NW'(depth1_reg);
            ny_reg   <= NW'(hd_reg) - (NW'(yf_reg) <<< 1) + NW'(depth1_reg);
            den2_reg <= {depth1_reg[DENW-2:0], 1'b0};
            beh2_reg <= beh1_reg;
        end
        if (ld[3]) begin
            neg_reg[0] <= nx_reg[NW-1];
            neg_reg[1] <= ny_reg[NW-1];
            mag_reg[0] <= nx_reg[NW-1] ? NW'(-nx_reg) : NW'(nx_reg);
            mag_reg[1] <= ny_reg[NW-1] ? NW'(-ny_reg) : NW'(ny_reg);
            den3_reg   <= den2_reg;
            beh3_reg   <= beh2_reg;
        end
    end

    assign out_valid  = v_reg[3];
    assign mag_out    = mag_reg;
    assign neg_out    = neg_reg;
    assign den_out    = den3_reg;
    assign behind_out = beh3_reg;

endmodule

@@ sv/vrp_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with floor, clamp and flags.
module vrp_div import vrp_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0][NW-1:0]                  mag_in,
    input  logic [1:0]                          neg_in,
    input  logic [DENW-1:0]                     den_in,
    input  logic                                behind_in,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0][COORD_WIDTH-1:0]         coord_out,
    output logic                                behind_out,
    output logic                                sat_out
);

    localparam int QB = COORD_WIDTH + 1;
    localparam int NS = QB + 2;
    localparam int RW = COORD_WIDTH + 3;
    localparam longint MaxL = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
    localparam logic signed [RW-1:0] MAXV = RW'(MaxL);
    localparam logic signed [RW-1:0] MINV = RW'(-MaxL - 1);

    logic [NS-1:0] v_reg, ld;

    logic [1:0][DENW-1:0] rem_reg [0:QB];
    logic [1:0][QB-1:0]   lo_reg  [0:QB];
    logic [1:0][QB-1:0]   q_reg   [0:QB];
    logic [1:0]           ovf_reg [0:QB];
    logic [1:0]           neg_reg [0:QB];
    logic [DENW-1:0]      den_reg [0:QB];
    logic                 beh_reg [0:QB];

    assign ld[NS-1] = !v_reg[NS-1] || out_ready;
    for (genvar j = 0; j < NS - 1; j++) begin : g_ld
        assign ld[j] = !v_reg[j] || ld[j+1];
    end
    assign in_ready = ld[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (ld[0]) v_reg[0] <= in_valid;
            for (int j = 1; j < NS; j++) begin
                if (ld[j]) v_reg[j] <= v_reg[j-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        logic [NW-1:0] hi;
        if (ld[0]) begin
            for (int l = 0; l < 2; l++) begin
                hi            = mag_in[l] >> QB;
                ovf_reg[0][l] <= hi >= NW'(den_in);
                rem_reg[0][l] <= hi[DENW-1:0];
                lo_reg[0][l]  <= mag_in[l][QB-1:0];
                q_reg[0][l]   <= '0;
            end
            neg_reg[0] <= neg_in;
            den_reg[0] <= den_in;
            beh_reg[0] <= behind_in;
        end
    end

    for (genvar j = 1; j <= QB; j++) begin : g_step
        always_ff @(posedge aclk) begin
            logic [DENW:0] t;
            logic          ge;
            if (ld[j]) begin
                for (int l = 0; l < 2; l++) begin
                    t  = {rem_reg[j-1][l], lo_reg[j-1][l][QB-1]};
                    ge = t >= {1'b0, den_reg[j-1]};
                    rem_reg[j][l] <= ge ? DENW'(t - {1'b0, den_reg[j-1]}) : t[DENW-1:0];
                    q_reg[j][l]   <= {q_reg[j-1][l][QB-2:0], ge};
                    lo_reg[j][l]  <= lo_reg[j-1][l] << 1;
                end
                ovf_reg[j] <= ovf_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
                den_reg[j] <= den_reg[j-1];
                beh_reg[j] <= beh_reg[j-1];
            end
        end
    end

    logic [1:0][COORD_WIDTH-1:0] coord_reg;
    logic                        beh_out_reg, sat_reg;

    always_ff @(posedge aclk) begin
        logic signed [RW-1:0] qv;
        logic signed [RW-1:0] rv;
        logic                 sat;
        if (ld[NS-1]) begin
            sat = 1'b0;
            for (int l = 0; l < 2; l++) begin
                qv = $signed(RW'(q_reg[QB][l]));
                rv = neg_reg[QB][l] ? -(qv + RW'(rem_reg[QB][l] != '0)) : qv;
                if (beh_reg[QB]) begin
                    coord_reg[l] <= '0;
                end else if (ovf_reg[QB][l]) begin
                    sat = 1'b1;
                    coord_reg[l] <= neg_reg[QB][l] ? COORD_WIDTH'(MINV) : COORD_WIDTH'(MAXV);
                end else if (rv > MAXV) begin
                    sat = 1'b1;
                    coord_reg[l] <= COORD_WIDTH'(MAXV);
                end else if (rv < MINV) begin
                    sat = 1'b1;
                    coord_reg[l] <= COORD_WIDTH'(MINV);
                end else begin
                    coord_reg[l] <= COORD_WIDTH'(rv);
                end
            end
            sat_reg     <= sat && !beh_reg[QB];
            beh_out_reg <= beh_reg[QB];
        end
    end

    assign out_valid  = v_reg[NS-1];
    assign coord_out  = coord_reg;
    assign behind_out = beh_out_reg;
    assign sat_out    = sat_reg;

endmodule

@@ sv/vertex_rotate_project.sv @@
// Top level: configuration registers, rotation chain, projection and divide pipeline.
//
// Takes one Q4.12 vertex per clock while s_tready is high and returns one screen point
// per vertex in order, passing each through the three rotations, the registered
// projection products and the divider, one quotient bit per stage.
// After reset and after every angle write the sine/cosine sequencer reads the sine ROM one
// entry a cycle, holding s_tready low until sin/cos update. cfg_ready is always high.
module vertex_rotate_project import vrp_pkg::*; #(
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
    parameter int COORD_WIDTH      = COORD_WIDTH_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic [3*VW-1:0]                           s_tdata,   // vertex_x, vertex_y, vertex_z
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]        m_tdata,   // screen_x, screen_y, zero pad
    output logic [1:0]                                m_tuser,   // behind_camera, saturated
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [CFG_IW-1:0]                         cfg_index,
    input  logic [CFG_DW-1:0]                         cfg_data
);

    localparam int TDW = ((2 * COORD_WIDTH + 7) / 8) * 8;

    logic [2:0][ANGW-1:0] angle_reg;
    logic [FW-1:0]        focal_reg, cam_reg;
    logic [SCW-1:0]       width_reg, height_reg;
    logic                 cfg_wr, angle_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign angle_wr  = cfg_wr && (cfg_index == REG_ANGLE_X || cfg_index == REG_ANGLE_Y ||
                                  cfg_index == REG_ANGLE_Z);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_reg  <= '0;
            focal_reg  <= FOCAL_RESET;
            cam_reg    <= CAMERA_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                REG_ANGLE_X:       angle_reg[0] <= cfg_data[ANGW-1:0];
                REG_ANGLE_Y:       angle_reg[1] <= cfg_data[ANGW-1:0];
                REG_ANGLE_Z:       angle_reg[2] <= cfg_data[ANGW-1:0];
                REG_FOCAL_SCALE:   focal_reg    <= cfg_data;
                REG_CAMERA_DIST:   cam_reg      <= cfg_data;
                REG_SCREEN_WIDTH:  width_reg    <= cfg_data[SCW-1:0];
                REG_SCREEN_HEIGHT: height_reg   <= cfg_data[SCW-1:0];
                default: ;
            endcase
        end
    end

    logic                             busy;
    logic signed [2:0][TRW-1:0]       sin_val, cos_val;

    vrp_coef #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_coef (
        .aclk(aclk), .aresetn(aresetn), .start(angle_wr), .angle(angle_reg),
        .busy(busy), .sin_val(sin_val), .cos_val(cos_val)
    );

    logic r1_in_ready, r1_valid, r2_ready, r2_valid, r3_ready, r3_valid;
    logic pj_ready, pj_valid, dv_ready;
    logic signed [R1W-1:0] x1, y1;
    logic signed [VW-1:0]  z1;
    logic signed [R2W-1:0] z2, x2;
    logic signed [R1W-1:0] y2;
    logic signed [R3W-1:0] y3, z3;
    logic signed [R2W-1:0] x3;

    assign s_tready = r1_in_ready && !busy;

    vrp_rot #(.AW(VW), .PW(VW)) u_rot_z (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid && !busy), .in_ready(r1_in_ready),
        .a_in($signed(s_tdata[VW-1:0])), .b_in($signed(s_tdata[2*VW-1:VW])),
        .p_in($signed(s_tdata[3*VW-1:2*VW])), .sin_val(sin_val[2]), .cos_val(cos_val[2]),
        .out_valid(r1_valid), .out_ready(r2_ready), .u_out(x1), .v_out(y1), .p_out(z1)
    );

    vrp_rot #(.AW(R1W), .PW(R1W)) u_rot_y (
        .aclk(aclk), .aresetn(aresetn), .in_valid(r1_valid), .in_ready(r2_ready),
        .a_in(R1W'(z1)), .b_in(x1), .p_in(y1), .sin_val(sin_val[1]), .cos_val(cos_val[1]),
        .out_valid(r2_valid), .out_ready(r3_ready), .u_out(z2), .v_out(x2), .p_out(y2)
    );

    vrp_rot #(.AW(R2W), .PW(R2W)) u_rot_x (
        .aclk(aclk), .aresetn(aresetn), .in_valid(r2_valid), .in_ready(r3_ready),
        .a_in(R2W'(y2)), .b_in(z2), .p_in(x2), .sin_val(sin_val[0]), .cos_val(cos_val[0]),
        .out_valid(r3_valid), .out_ready(pj_ready), .u_out(y3), .v_out(z3), .p_out(x3)
    );

    logic [1:0][NW-1:0] mag;
    logic [1:0]         neg;
    logic [DENW-1:0]    den;
    logic               behind;

    vrp_proj u_proj (
        .aclk(aclk), .aresetn(aresetn), .in_valid(r3_valid), .in_ready(pj_ready),
        .x_in(x3), .y_in(y3), .z_in(z3), .cam_dist(cam_reg), .focal(focal_reg),
        .scr_w(width_reg), .scr_h(height_reg), .out_valid(pj_valid), .out_ready(dv_ready),
        .mag_out(mag), .neg_out(neg), .den_out(den), .behind_out(behind)
    );

    logic [1:0][COORD_WIDTH-1:0] coord;
    logic                        behind_q, sat_q;

    vrp_div #(.COORD_WIDTH(COORD_WIDTH)) u_div (
        .aclk(aclk), .aresetn(aresetn), .in_valid(pj_valid), .in_ready(dv_ready),
        .mag_in(mag), .neg_in(neg), .den_in(den), .behind_in(behind),
        .out_valid(m_tvalid), .out_ready(m_tready), .coord_out(coord),
        .behind_out(behind_q), .sat_out(sat_q)
    );

    assign m_tdata = TDW'({coord[1], coord[0]});
    assign m_tuser = {sat_q, behind_q};

    a_behind_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
        else $error("behind-camera item with nonzero coordinates or saturation");

    a_busy_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !s_tready)
        else $error("item accepted while coefficients update");

    a_angle_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        angle_wr |=> busy)
        else $error("angle write did not start coefficient update");

endmodule

@@ tb/vertex_rotate_project_tb.sv @@
// Self-checking testbench for the vertex rotation and projection pipeline.
module vertex_rotate_project_tb import vrp_pkg::*;;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int QDEPTH         = 1024;

    localparam logic [CFG_IW-1:0] REG_UNMAPPED = 3'd7;

    typedef struct packed {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic               behind;
        logic               sat;
    } point_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [3*VW-1:0]     s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [31:0]         m_tdata;
    logic [1:0]          m_tuser;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_IW-1:0]   cfg_index = '0;
    logic [CFG_DW-1:0]   cfg_data = '0;

    logic [3*VW-1:0]     vertex_q [$];
    point_t              point_q [$];
    longint              quarter_sine [0:QDEPTH];
    logic [11:0]         ang_x, ang_y, ang_z;
    logic [15:0]         focal, cam_dist;
    logic [13:0]         scr_w, scr_h;
    int                  errors = 0;
    int                  s_gap = 0;
    int                  m_stall = 0;
    int                  idle_cycles = 0;
    bit                  quiet = 1'b0;

    vertex_rotate_project dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #1 aclk = ~aclk;

    function automatic longint sine_entry(longint unsigned r);
        longint unsigned th, th2, term, acc;
        th   = (r * 64'd1686629713) / QDEPTH;
        th2  = (th * th) >> 30;
        term = th;
        acc  = th;
        for (int n = 1; n <= 8; n++) begin
            term = ((term * th2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
        end
        return longint'((acc + (64'd1 << 17)) >> 18);
    endfunction

    function automatic void sin_cos(input logic [11:0] ang, output longint s, output longint c);
        longint a, k, r, lo, hi;
        a  = (longint'(ang) * QDEPTH) >> 12;
        k  = (4 * a) / QDEPTH;
        r  = 4 * a - k * QDEPTH;
        lo = quarter_sine[r];
        hi = quarter_sine[QDEPTH - r];
        case (k)
            0: begin s = lo;  c = hi;  end
            1: begin s = hi;  c = -lo; end
            2: begin s = -lo; c = -hi; end
            default: begin s = -hi; c = lo; end
        endcase
    endfunction

    function automatic longint fdiv(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && ((n < 0) != (d < 0))) begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic longint rq12(longint v);
        return (v + 2048) >>> 12;
    endfunction

    function automatic longint clamp16(longint v, inout logic sat);
        if (v > 32767) begin
            sat = 1'b1;
            return 32767;
        end
        if (v < -32768) begin
            sat = 1'b1;
            return -32768;
        end
        return v;
    endfunction

    function automatic point_t project_vertex(logic [3*VW-1:0] v);
        longint x, y, z, sx, cx, sy, cy, sz, cz;
        longint x1, y1, x2, z2, y3, z3, depth, px, py;
        point_t p;
        x = longint'($signed(v[15:0]));
        y = longint'($signed(v[31:16]));
        z = longint'($signed(v[47:32]));
        sin_cos(ang_x, sx, cx);
        sin_cos(ang_y, sy, cy);
        sin_cos(ang_z, sz, cz);
        x1 = rq12(x * cz - y * sz);
        y1 = rq12(x * sz + y * cz);
        x2 = rq12(x1 * cy + z * sy);
        z2 = rq12(z * cy - x1 * sy);
        y3 = rq12(y1 * cx - z2 * sx);
        z3 = rq12(y1 * sx + z2 * cx);
        depth = z3 + longint'(cam_dist);
        p = '0;
        if (depth <= 0) begin
            p.behind = 1'b1;
            return p;
        end
        px = fdiv(longint'(scr_w) * depth + 2 * x2 * longint'(focal) + depth, 2 * depth);
        py = fdiv(longint'(scr_h) * depth - 2 * y3 * longint'(focal) + depth, 2 * depth);
        p.sx = 16'(clamp16(px, p.sat));
        p.sy = 16'(clamp16(py, p.sat));
        return p;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (quiet) begin
                s_gap = 0;
            end
            if (s_gap > 0) begin
                s_gap = s_gap - 1;
                s_tvalid <= 1'b0;
            end else if (vertex_q.size() > 0 && !quiet && $urandom_range(0, 9) == 0) begin
                s_gap = $urandom_range(0, 10);
                s_tvalid <= 1'b0;
            end else if (vertex_q.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= vertex_q.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || quiet) begin
            m_stall = 0;
            m_tready <= aresetn;
        end else if (m_stall > 0) begin
            m_stall = m_stall - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            m_stall = $urandom_range(0, 10);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        point_t got, want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ANGLE_X:       ang_x = cfg_data[11:0];
                    REG_ANGLE_Y:       ang_y = cfg_data[11:0];
                    REG_ANGLE_Z:       ang_z = cfg_data[11:0];
                    REG_FOCAL_SCALE:   focal = cfg_data;
                    REG_CAMERA_DIST:   cam_dist = cfg_data;
                    REG_SCREEN_WIDTH:  scr_w = cfg_data[13:0];
                    REG_SCREEN_HEIGHT: scr_h = cfg_data[13:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                point_q.push_back(project_vertex(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                got = {m_tdata[15:0], m_tdata[31:16], m_tuser[0], m_tuser[1]};
                if (point_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("unexpected point x=%0d y=%0d", got.sx, got.sy);
                    end
                end else begin
                    want = point_q.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10) begin
                            $display({"mismatch: exp x=%0d y=%0d bc=%0b sat=%0b, ",
                                      "got x=%0d y=%0d bc=%0b sat=%0b"},
                                     want.sx, want.sy, want.behind, want.sat,
                                     got.sx, got.sy, got.behind, got.sat);
                        end
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("== FAIL ==");
                    $finish;
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        do @(posedge aclk); while (vertex_q.size() > 0 || s_tvalid || point_q.size() > 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 4))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
            2: return 16'($signed($urandom_range(0, 16384)) - 8192);
            default: return 16'($signed($urandom_range(0, 4096)) - 2048);
        endcase
    endfunction

    task automatic push_random(int n);
        repeat (n) vertex_q.push_back({pick_coord(), pick_coord(), pick_coord()});
    endtask

    task automatic set_all(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                           logic [15:0] f, logic [15:0] cd, logic [15:0] w, logic [15:0] h);
        write_reg(REG_ANGLE_X, ax);
        write_reg(REG_ANGLE_Y, ay);
        write_reg(REG_ANGLE_Z, az);
        write_reg(REG_FOCAL_SCALE, f);
        write_reg(REG_CAMERA_DIST, cd);
        write_reg(REG_SCREEN_WIDTH, w);
        write_reg(REG_SCREEN_HEIGHT, h);
    endtask

    initial begin
        for (int r = 0; r <= QDEPTH; r++) begin
            quarter_sine[r] = sine_entry(r);
        end
        ang_x = '0; ang_y = '0; ang_z = '0;
        focal = FOCAL_RESET; cam_dist = CAMERA_RESET;
        scr_w = WIDTH_RESET; scr_h = HEIGHT_RESET;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed corners under reset settings
        vertex_q.push_back({16'h0000, 16'h0000, 16'h0000});
        vertex_q.push_back({16'h0000, 16'h7FFF, 16'h7FFF});
        vertex_q.push_back({16'h0000, 16'h8000, 16'h8000});
        vertex_q.push_back({16'h7FFF, 16'h0000, 16'h0000});
        vertex_q.push_back({16'h8000, 16'h1000, 16'hF000});
        vertex_q.push_back({16'hC000, 16'h0800, 16'h0800});
        vertex_q.push_back({16'hC001, 16'h0000, 16'h0000});
        vertex_q.push_back({16'hBFFF, 16'h7FFF, 16'h8000});
        vertex_q.push_back({16'hFFFF, 16'hFFFF, 16'hFFFF});
        vertex_q.push_back({16'hC100, 16'h7FFF, 16'h7FFF});
        drain();

        // rotated, large focal: saturation
        set_all(16'd1024, 16'd2048, 16'd3072, 16'hFFFF, 16'h4000, 16'd8192, 16'd8192);
        write_reg(REG_UNMAPPED, 16'h1234);
        vertex_q.push_back({16'h0000, 16'h0000, 16'h7FFF});
        vertex_q.push_back({16'h0000, 16'h7FFF, 16'h8000});
        vertex_q.push_back({16'h7FFF, 16'h8000, 16'h0000});
        vertex_q.push_back({16'h0100, 16'h0100, 16'h0100});
        push_random(60);
        drain();

        // zero focal, zero screen, zero camera distance, masked upper bits
        set_all(16'hFFFF, 16'hF001, 16'h0FFF, 16'd0, 16'd0, 16'd0, 16'hC000);
        vertex_q.push_back({16'h0000, 16'h0000, 16'h0000});
        vertex_q.push_back({16'h7FFF, 16'h7FFF, 16'h7FFF});
        push_random(60);
        drain();

        set_all(16'd0, 16'd0, 16'd0, 16'd200, 16'hFFFF, 16'd1, 16'd1);
        push_random(80);
        drain();

        repeat (6) begin
            set_all(16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom_range(0, 2000)), 16'($urandom_range(0, 65535)),
                    16'($urandom_range(1, 8192)), 16'($urandom_range(1, 8192)));
            push_random(80);
            drain();
        end

        quiet = 1'b1;
        set_all(16'd512, 16'd100, 16'd3000, 16'd400, 16'd20000, 16'd1280, 16'd720);
        push_random(120);
        drain();

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/vrp_pkg.sv
sv/vrp_coef.sv
sv/vrp_rot.sv
sv/vrp_proj.sv
sv/vrp_div.sv
sv/vertex_rotate_project.sv
tb/vertex_rotate_project_tb.sv
